>>> rtl/core/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the gas sensor ppm alarm
// Holds the controller state type, fixed-point constants and the
// elaboration-time builders for the logarithm and root tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

	// Controller states of the conversion sequencer.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RS_START,
		ST_RS_DIV,
		ST_BRANCH,
		ST_CAL_DIV,
		ST_NORM,
		ST_LOG_MUL,
		ST_LOG_WAIT,
		ST_SLOPE,
		ST_EXP,
		ST_ROOT,
		ST_ROOT_WAIT,
		ST_ROUND,
		ST_FINISH
	} gsa_state_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_NOTIFY = 2'd0,
		REG_ALERT  = 2'd1,
		REG_RAPID  = 2'd2,
		REG_CAL    = 2'd3
	} gsa_reg_t;

	localparam int unsigned CFG_W      = 10;
	localparam int unsigned RS_W       = 20;
	localparam int unsigned SUM_W      = 28;
	localparam int unsigned PPM_W      = 14;
	localparam int unsigned LOG_W      = 21;
	localparam int unsigned ROOT_COUNT = 16;

	localparam logic [PPM_W-1:0] PPM16_MAX = 14'd16000;
	localparam int unsigned      RS_MIN    = 100;
	localparam int unsigned      RS_MAX    = 1000000;
	localparam logic [RS_W-1:0]  RO_RESET  = 20'd10000;

	// 0.45 and (1.2*log2(10) + 4), both in Q16.
	localparam logic signed [36:0] SLOPE_Q16  = 37'sd29491;
	localparam logic signed [23:0] EXP_OFFSET = 24'sd523391;
	localparam logic signed [23:0] EXP_FLOOR  = -24'sd2097152;

	// Truncating integer square root of a 64-bit value.
	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bit_v;
		res   = '0;
		rem   = v;
		bit_v = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (bit_v > v) bit_v = bit_v >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bit_v != 64'd0) begin
				if (rem >= res + bit_v) begin
					rem = rem - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
		end
		return res;
	endfunction

	// Q30 root 2^(2^-(k+1)), built as a chain of square roots.
	function automatic logic [63:0] root_entry(int unsigned k);
		logic [63:0] r;
		r = isqrt64(64'd1 << 61);
		for (int unsigned j = 1; j <= k; j++) begin
			r = isqrt64(r << 30);
		end
		return r;
	endfunction

	// Q16 log2 of a Q30 mantissa in [1, 2) by repeated squaring.
	function automatic logic [16:0] log_entry(logic [63:0] x0);
		logic [63:0] x;
		logic [17:0] acc;
		x   = x0;
		acc = '0;
		for (int b = 0; b < 17; b++) begin
			x   = (x * x) >> 30;
			acc = acc << 1;
			if (x >= (64'd1 << 31)) begin
				acc[0] = 1'b1;
				x      = x >> 1;
			end
		end
		acc = acc + 18'd1;
		return acc[17:1];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/gsa_serial_mul.sv
// ----------------------------------------------------------------------------
// gsa_serial_mul: bit-serial unsigned multiplier
// Forms a 32 by 32 bit product with one shift-and-add step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_serial_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] op_a,
	input  wire logic [31:0] op_b,
	output logic             done,
	output logic [63:0]      product
);

	logic [31:0] a_q;
	logic [63:0] prod_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] partial;

	// One multiplier bit is consumed per cycle from the low end.
	assign partial = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, a_q} : 33'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and product shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= op_a;
			prod_q <= {32'd0, op_b};
		end else if (busy_q) begin
			prod_q <= {partial, prod_q[31:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

`default_nettype wire

>>> rtl/core/gsa_serial_div.sv
// ----------------------------------------------------------------------------
// gsa_serial_div: restoring unsigned divider
// Produces one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_serial_div #(
	parameter int unsigned NUM_W = 32,
	parameter int unsigned DEN_W = 22
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	input  wire logic [DEN_W-1:0] denom,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = ~trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/gas_sensor_ppm_alarm_top.sv
// ----------------------------------------------------------------------------
// gas_sensor_ppm_alarm_top: gas concentration converter with alarm flags
// Turns converter samples into sensor resistance, averages calibration
// samples into a baseline and converts measurements into 1/16 ppm.
// ----------------------------------------------------------------------------
// The block handles one request at a time and returns one result per request.
// The sensor resistance comes from a restoring divider. A calibration request
// that closes a run uses the divider again for the baseline average. A
// measurement takes two logarithms, each a normalizing shift and a serial
// product, then one serial product for each set fraction bit of the exponent
// (up to 16). A new request is taken while the previous result still waits
// in the output register.
`default_nettype none

module gas_sensor_ppm_alarm_top #(
	parameter int unsigned ADC_BITS          = 12,
	parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       cmd,
	input  wire logic [ADC_BITS-1:0]        adc_sample,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [gsa_pkg::PPM_W-1:0]       ppm_sixteenths,
	output logic                            notify,
	output logic                            alert,
	output logic                            rapid_rise,
	output logic                            alarm_led,
	output logic                            calibrated,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [gsa_pkg::CFG_W-1:0]  cfg_data
);

	import gsa_pkg::*;

	localparam int unsigned NUM_W   = ADC_BITS + 20;
	localparam int unsigned DEN_W   = ADC_BITS + 6;
	localparam int unsigned CHK_W   = ADC_BITS + 9;
	localparam int unsigned LI_W    = $clog2(LOG_TABLE_ENTRIES + 1);
	localparam int unsigned S_W     = 31 + LI_W;
	localparam logic [CHK_W-1:0] FULL_CHK = CHK_W'((64'd1 << ADC_BITS) - 64'd1);
	localparam logic [DEN_W-1:0] FULL_50  = DEN_W'(((64'd1 << ADC_BITS) - 64'd1) * 64'd50);
	localparam logic [LI_W-1:0]  IDX_MAX  = LI_W'(LOG_TABLE_ENTRIES - 1);

	// Constant tables built at elaboration.
	logic [16:0] log_rom [0:LOG_TABLE_ENTRIES];
	logic [31:0] root_rom [ROOT_COUNT];

	for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_log
		localparam logic [63:0] LogX0 =
			((64'(LOG_TABLE_ENTRIES) + 64'(gi)) << 30) / 64'(LOG_TABLE_ENTRIES);
		localparam logic [16:0] LogVal =
			(gi == LOG_TABLE_ENTRIES) ? 17'd65536 : log_entry(LogX0);
		assign log_rom[gi] = LogVal;
	end

	for (genvar gk = 0; gk < ROOT_COUNT; gk++) begin : g_root
		localparam logic [63:0] RootVal = root_entry(gk);
		assign root_rom[gk] = RootVal[31:0];
	end

	// Configuration and persistent state.
	logic [CFG_W-1:0] notify_thr_q;
	logic [CFG_W-1:0] alert_thr_q;
	logic [CFG_W-1:0] rapid_thr_q;
	logic [7:0]       cal_samples_q;
	logic [RS_W-1:0]  ro_q;
	logic [SUM_W-1:0] cal_sum_q;
	logic [7:0]       cal_count_q;
	logic [PPM_W-1:0] prev_ppm_q;
	logic             cal_done_q;

	// Working registers.
	gsa_state_t           state_q, state_d;
	logic                 cmd_q;
	logic [ADC_BITS-1:0]  adc_q;
	logic [RS_W-1:0]      rs_q;
	logic [RS_W-1:0]      norm_q;
	logic [4:0]           exp2_q;
	logic                 pass_q;
	logic [16:0]          lo_q;
	logic [LOG_W-1:0]     lrs_q;
	logic [LOG_W-1:0]     lro_q;
	logic signed [36:0]   slope_q;
	logic signed [7:0]    n_q;
	logic [15:0]          f_q;
	logic [4:0]           k_q;
	logic [31:0]          pw_q;
	logic [PPM_W-1:0]     ppm_q;

	// Output registers.
	logic             out_valid_q;
	logic [PPM_W-1:0] ppm_out_q;
	logic             notify_q;
	logic             alert_q;
	logic             rapid_q;
	logic             cal_out_q;

	// Shared arithmetic units.
	logic             mul_start;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic             mul_done;
	logic [63:0]      mul_prod;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	gsa_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	gsa_serial_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_num),
		.denom    (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sensor resistance operands and the valid sample range.
	logic [DEN_W-1:0] adc_33;
	logic [CHK_W-1:0] adc_330;
	logic             range_ok;
	logic [NUM_W-1:0] rs_num;

	assign adc_33   = DEN_W'(adc_q) * DEN_W'(33);
	assign adc_330  = CHK_W'(adc_q) * CHK_W'(330);
	assign range_ok = (adc_330 > FULL_CHK) && (adc_33 < FULL_50);
	assign rs_num   = NUM_W'(14'd10000) * NUM_W'(FULL_50 - adc_33);

	// Calibration bookkeeping.
	logic [SUM_W-1:0] sum_next;
	logic [7:0]       count_next;
	logic [7:0]       cal_target;
	logic             cal_close;
	logic [8:0]       cal_div;

	assign sum_next   = cal_sum_q + SUM_W'(rs_q);
	assign count_next = cal_count_q + 8'd1;
	assign cal_target = (cal_samples_q == 8'd0) ? 8'd1 : cal_samples_q;
	assign cal_close  = (count_next >= cal_target) || (count_next == 8'd0);
	assign cal_div    = (count_next == 8'd0) ? 9'd256 : {1'b0, count_next};

	// Table lookup for the logarithm fraction.
	logic [30:0]     frac31;
	logic [S_W-1:0]  frac_scaled;
	logic [LI_W-1:0] idx_raw;
	logic [LI_W-1:0] idx;
	logic [LI_W-1:0] idx_hi;
	logic [16:0]     tab_lo;
	logic [16:0]     tab_hi;
	logic [LOG_W-1:0] log_val;

	assign frac31      = {norm_q[RS_W-2:0], 12'd0};
	assign frac_scaled = S_W'(frac31) * S_W'(LOG_TABLE_ENTRIES);
	assign idx_raw     = frac_scaled[S_W-1:31];
	assign idx         = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
	assign idx_hi      = idx + LI_W'(1);
	assign tab_lo      = log_rom[idx];
	assign tab_hi      = log_rom[idx_hi];
	assign log_val     = {exp2_q, 16'd0} + LOG_W'(lo_q) + LOG_W'(mul_prod[47:31]);

	// Exponent split into integer and fraction.
	logic signed [21:0] log_diff;
	logic signed [36:0] slope_d;
	logic signed [36:0] slope_rnd;
	logic signed [20:0] m_val;
	logic signed [23:0] e_val;
	logic signed [7:0]  e_int;

	assign log_diff  = $signed({1'b0, lrs_q}) - $signed({1'b0, lro_q});
	assign slope_d   = 37'(log_diff) * SLOPE_Q16;
	assign slope_rnd = slope_q + 37'sd32768;
	assign m_val     = slope_rnd[36:16];
	assign e_val     = EXP_OFFSET - 24'(m_val);
	assign e_int     = e_val[23:16];

	// Final scaling with round half up.
	logic signed [8:0] shamt;
	logic [31:0]       pw_shift;
	logic [32:0]       rounded;
	logic [PPM_W-1:0]  ppm_round;

	assign shamt     = 9'sd29 - 9'(n_q);
	assign pw_shift  = (shamt > 9'sd31) ? 32'd0 : (pw_q >> shamt[4:0]);
	assign rounded   = ({1'b0, pw_shift} + 33'd1) >> 1;
	assign ppm_round = (rounded > 33'(PPM16_MAX)) ? PPM16_MAX : rounded[PPM_W-1:0];

	// Alarm flags of the finished measurement.
	logic [PPM_W:0] rise;
	logic           nt_flag;
	logic           al_flag;
	logic           rr_flag;

	assign rise    = {1'b0, ppm_q} - {1'b0, prev_ppm_q};
	assign nt_flag = ~cmd_q && ({1'b0, ppm_q} > {1'b0, notify_thr_q, 4'd0});
	assign al_flag = ~cmd_q && ({1'b0, ppm_q} > {1'b0, alert_thr_q, 4'd0});
	assign rr_flag = ~cmd_q && (prev_ppm_q != '0) && (ppm_q > prev_ppm_q)
		&& (rise > {1'b0, rapid_thr_q, 4'd0});

	logic out_free;
	assign out_free = ~out_valid_q || out_ready;

	// Next state and unit control.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = {15'd0, tab_hi - tab_lo};
		mul_b     = {1'b0, frac_scaled[30:0]};
		div_start = 1'b0;
		div_num   = rs_num;
		div_den   = adc_33;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_RS_START;
			end
			ST_RS_START: begin
				if (range_ok) begin
					div_start = 1'b1;
					state_d   = ST_RS_DIV;
				end else begin
					state_d = ST_BRANCH;
				end
			end
			ST_RS_DIV: begin
				if (div_done) state_d = ST_BRANCH;
			end
			ST_BRANCH: begin
				div_num = NUM_W'(sum_next);
				div_den = DEN_W'(cal_div);
				if (cmd_q) begin
					if (cal_close) begin
						div_start = 1'b1;
						state_d   = ST_CAL_DIV;
					end else begin
						state_d = ST_FINISH;
					end
				end else if (rs_q == '0 || ro_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_CAL_DIV: begin
				if (div_done) state_d = ST_FINISH;
			end
			ST_NORM: begin
				if (norm_q[RS_W-1]) state_d = ST_LOG_MUL;
			end
			ST_LOG_MUL: begin
				mul_start = 1'b1;
				state_d   = ST_LOG_WAIT;
			end
			ST_LOG_WAIT: begin
				if (mul_done) state_d = pass_q ? ST_SLOPE : ST_NORM;
			end
			ST_SLOPE: begin
				state_d = ST_EXP;
			end
			ST_EXP: begin
				priority if (e_val < EXP_FLOOR) state_d = ST_FINISH;
				else if (e_int >= 8'sd14)       state_d = ST_FINISH;
				else                            state_d = ST_ROOT;
			end
			ST_ROOT: begin
				mul_a = pw_q;
				mul_b = root_rom[k_q[3:0]];
				priority if (k_q[4]) begin
					state_d = ST_ROUND;
				end else if (f_q[~k_q[3:0]]) begin
					mul_start = 1'b1;
					state_d   = ST_ROOT_WAIT;
				end else begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT_WAIT: begin
				if (mul_done) state_d = ST_ROOT;
			end
			ST_ROUND: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers and state that persists between requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notify_thr_q  <= 10'd35;
			alert_thr_q   <= 10'd50;
			rapid_thr_q   <= 10'd10;
			cal_samples_q <= 8'd50;
			ro_q          <= RO_RESET;
			cal_sum_q     <= '0;
			cal_count_q   <= '0;
			prev_ppm_q    <= '0;
			cal_done_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (gsa_reg_t'(cfg_index))
					REG_NOTIFY: notify_thr_q  <= cfg_data;
					REG_ALERT:  alert_thr_q   <= cfg_data;
					REG_RAPID:  rapid_thr_q   <= cfg_data;
					REG_CAL:    cal_samples_q <= cfg_data[7:0];
					default:    ;
				endcase
			end
			if (state_q == ST_BRANCH && cmd_q) begin
				cal_sum_q   <= cal_close ? '0 : sum_next;
				cal_count_q <= cal_close ? '0 : count_next;
			end
			if (state_q == ST_CAL_DIV && div_done) begin
				ro_q       <= div_quo[RS_W-1:0];
				cal_done_q <= 1'b1;
			end
			if (state_q == ST_FINISH && out_free && !cmd_q) begin
				prev_ppm_q <= ppm_q;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				adc_q <= adc_sample;
				ppm_q <= '0;
			end
			ST_RS_START: begin
				rs_q <= '0;
			end
			ST_RS_DIV: begin
				if (div_done) begin
					rs_q <= (div_quo > NUM_W'(RS_MIN) && div_quo <= NUM_W'(RS_MAX))
						? div_quo[RS_W-1:0] : '0;
				end
			end
			ST_BRANCH: begin
				norm_q <= rs_q;
				exp2_q <= 5'd19;
				pass_q <= 1'b0;
			end
			ST_NORM: begin
				if (!norm_q[RS_W-1]) begin
					norm_q <= {norm_q[RS_W-2:0], 1'b0};
					exp2_q <= exp2_q - 5'd1;
				end
			end
			ST_LOG_MUL: begin
				lo_q <= tab_lo;
			end
			ST_LOG_WAIT: begin
				if (mul_done) begin
					if (pass_q) begin
						lro_q <= log_val;
					end else begin
						lrs_q  <= log_val;
						norm_q <= ro_q;
						exp2_q <= 5'd19;
						pass_q <= 1'b1;
					end
				end
			end
			ST_SLOPE: begin
				slope_q <= slope_d;
			end
			ST_EXP: begin
				priority if (e_val < EXP_FLOOR) ppm_q <= '0;
				else if (e_int >= 8'sd14)       ppm_q <= PPM16_MAX;
				else                            ppm_q <= ppm_q;
				n_q  <= e_int;
				f_q  <= e_val[15:0];
				k_q  <= '0;
				pw_q <= 32'h4000_0000;
			end
			ST_ROOT: begin
				if (!k_q[4] && !f_q[~k_q[3:0]]) k_q <= k_q + 5'd1;
			end
			ST_ROOT_WAIT: begin
				if (mul_done) begin
					pw_q <= mul_prod[61:30];
					k_q  <= k_q + 5'd1;
				end
			end
			ST_ROUND: begin
				ppm_q <= ppm_round;
			end
			ST_FINISH: begin
				if (out_free) begin
					ppm_out_q <= ppm_q;
					notify_q  <= nt_flag;
					alert_q   <= al_flag;
					rapid_q   <= rr_flag;
					cal_out_q <= cal_done_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign ppm_sixteenths = ppm_out_q;
	assign notify         = notify_q;
	assign alert          = alert_q;
	assign rapid_rise     = rapid_q;
	assign alarm_led      = alert_q | rapid_q;
	assign calibrated     = cal_out_q;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the gas sensor ppm alarm
// Drives calibration and measurement requests over a valid/ready channel,
// predicts every result in a scoreboard with its own fixed-point conversion
// and compares each returned result field by field, with and without random stalls.
// ----------------------------------------------------------------------------

module tb_top;
	import gsa_pkg::*;

	localparam int unsigned ADC_FULL    = 4095;
	localparam int unsigned LOG_N       = 64;
	localparam longint      CYCLE_LIMIT = 10000000;

	typedef struct packed {
		logic [PPM_W-1:0] ppm;
		logic             notify;
		logic             alert;
		logic             rapid;
		logic             led;
		logic             cal_done;
	} alarm_result_t;

	// Scoreboard: holds a copy of the converter state and the expected results.
	class alarm_scoreboard;
		int unsigned       thr_notify, thr_alert, thr_rapid, cal_target;
		int unsigned       ro, cal_sum, cal_count, last_ppm, cal_done;
		int unsigned       log_rom[LOG_N + 1];
		longint unsigned   root_rom[16];
		alarm_result_t     expected_q[$];
		int                errors;

		function new();
			thr_notify = 35;
			thr_alert  = 50;
			thr_rapid  = 10;
			cal_target = 50;
			ro         = 10000;
			cal_sum    = 0;
			cal_count  = 0;
			last_ppm   = 0;
			cal_done   = 0;
			errors     = 0;
			build_tables();
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function void build_tables();
			longint unsigned x;
			int unsigned acc;
			for (int i = 0; i < LOG_N; i++) begin
				x   = ((64'(LOG_N) + 64'(i)) << 30) / LOG_N;
				acc = 0;
				for (int b = 0; b < 17; b++) begin
					x   = (x * x) >> 30;
					acc = acc << 1;
					if (x >= (64'd1 << 31)) begin
						acc = acc | 1;
						x   = x >> 1;
					end
				end
				log_rom[i] = (acc + 1) >> 1;
			end
			log_rom[LOG_N] = 65536;
			root_rom[0] = int_sqrt(64'd1 << 61);
			for (int k = 1; k < 16; k++) root_rom[k] = int_sqrt(root_rom[k - 1] << 30);
		endfunction

		function void set_reg(gsa_reg_t idx, int unsigned value);
			case (idx)
				REG_NOTIFY: thr_notify = value & 10'h3FF;
				REG_ALERT:  thr_alert  = value & 10'h3FF;
				REG_RAPID:  thr_rapid  = value & 10'h3FF;
				REG_CAL:    cal_target = value & 8'hFF;
				default: ;
			endcase
		endfunction

		function int unsigned sensor_ohms(int unsigned a);
			longint unsigned rs;
			if (330 * 64'(a) <= ADC_FULL) return 0;
			if (33 * 64'(a) >= 50 * 64'(ADC_FULL)) return 0;
			rs = (10000 * (50 * 64'(ADC_FULL) - 33 * 64'(a))) / (33 * 64'(a));
			if (rs <= 100 || rs > 1000000) return 0;
			return int'(rs);
		endfunction

		function longint log2_q16(int unsigned v);
			int unsigned p, t, idx, lo, hi;
			longint unsigned m, s, rem;
			p = 0;
			t = v;
			while (t > 1) begin
				t = t >> 1;
				p++;
			end
			m   = (64'(v) << (31 - p)) - (64'd1 << 31);
			s   = m * LOG_N;
			idx = int'(s >> 31);
			if (idx > LOG_N - 1) idx = LOG_N - 1;
			rem = s & 64'h7FFF_FFFF;
			lo  = log_rom[idx];
			hi  = log_rom[idx + 1];
			return longint'((64'(p) << 16) + lo + ((64'(hi - lo) * rem) >> 31));
		endfunction

		function int unsigned ppm16_of(int unsigned rs, int unsigned base);
			longint l, mm, e;
			longint unsigned eb, f, p;
			int n, sh;
			if (rs == 0 || base == 0) return 0;
			l  = log2_q16(rs) - log2_q16(base);
			mm = (l * 29491 + 32768) >>> 16;
			e  = 523391 - mm;
			if (e < -(64'sd32 << 16)) return 0;
			eb = longint'(e + (64'sd64 << 16));
			n  = int'(eb >> 16) - 64;
			f  = eb & 64'hFFFF;
			if (n >= 14) return 16000;
			p = 64'd1 << 30;
			for (int k = 0; k < 16; k++)
				if ((f >> (15 - k)) & 1) p = (p * root_rom[k]) >> 30;
			sh = 30 - n;
			if (sh > 62) return 0;
			p = (p + (64'd1 << (sh - 1))) >> sh;
			return (p > 16000) ? 16000 : int'(p);
		endfunction

		// Advances the state for one accepted request and queues its result.
		function void note_request(bit is_cal, int unsigned adc);
			alarm_result_t r;
			int unsigned rs, tgt, cnt, ppm;
			r  = '0;
			rs = sensor_ohms(adc & 12'hFFF);
			if (is_cal) begin
				tgt       = (cal_target != 0) ? cal_target : 1;
				cal_sum   = (cal_sum + rs) & 28'hFFF_FFFF;
				cal_count = (cal_count + 1) & 8'hFF;
				if (cal_count >= tgt || cal_count == 0) begin
					cnt       = (cal_count != 0) ? cal_count : 256;
					ro        = (cal_sum / cnt) & 20'hF_FFFF;
					cal_done  = 1;
					cal_sum   = 0;
					cal_count = 0;
				end
			end else begin
				ppm      = ppm16_of(rs, ro);
				r.ppm    = ppm[PPM_W-1:0];
				r.notify = ppm > 16 * thr_notify;
				r.alert  = ppm > 16 * thr_alert;
				r.rapid  = last_ppm != 0 && ppm > last_ppm && ppm - last_ppm > 16 * thr_rapid;
				r.led    = r.alert | r.rapid;
				last_ppm = ppm;
			end
			r.cal_done = cal_done[0];
			expected_q.push_back(r);
		endfunction

		// Compares one returned result with the oldest expected one.
		function void check_result(alarm_result_t got);
			alarm_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $realtime, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.ppm !== want.ppm) begin
				$display("%0t: ppm_sixteenths expected %0d actual %0d", $realtime, want.ppm, got.ppm);
				errors++;
			end
			if (got.notify !== want.notify) begin
				$display("%0t: notify expected %b actual %b", $realtime, want.notify, got.notify);
				errors++;
			end
			if (got.alert !== want.alert) begin
				$display("%0t: alert expected %b actual %b", $realtime, want.alert, got.alert);
				errors++;
			end
			if (got.rapid !== want.rapid) begin
				$display("%0t: rapid_rise expected %b actual %b", $realtime, want.rapid, got.rapid);
				errors++;
			end
			if (got.led !== want.led) begin
				$display("%0t: alarm_led expected %b actual %b", $realtime, want.led, got.led);
				errors++;
			end
			if (got.cal_done !== want.cal_done) begin
				$display("%0t: calibrated expected %b actual %b", $realtime,
					want.cal_done, got.cal_done);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	logic [11:0]          adc_sample;
	logic                 out_valid;
	logic                 out_ready;
	logic [PPM_W-1:0]     ppm_sixteenths;
	logic                 notify;
	logic                 alert;
	logic                 rapid_rise;
	logic                 alarm_led;
	logic                 calibrated;
	logic                 cfg_we;
	logic [1:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	alarm_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	longint          cycle_count;

	gas_sensor_ppm_alarm_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ppm_sixteenths (ppm_sixteenths),
		.notify         (notify),
		.alert          (alert),
		.rapid_rise     (rapid_rise),
		.alarm_led      (alarm_led),
		.calibrated     (calibrated),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog on the whole run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: check on acceptance, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({ppm_sixteenths, notify, alert, rapid_rise, alarm_led, calibrated});
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sends one request, sometimes after a random gap, and waits until it is accepted.
	task automatic send_request(bit is_cal, int unsigned adc);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= is_cal;
		adc_sample <= adc[11:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(is_cal, adc);
	endtask

	// Writes a register once the block has drained.
	task automatic write_reg(gsa_reg_t idx, int unsigned value);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	function automatic int unsigned pick_adc();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 15) return $urandom_range(70);
		if (sel < 25) return $urandom_range(4095, 4080);
		return $urandom_range(4095);
	endfunction

	task automatic random_phase(int unsigned count, int unsigned cal_pct);
		for (int i = 0; i < count; i++)
			send_request($urandom_range(99) < cal_pct, pick_adc());
	endtask

	initial begin
		sb            = new();
		send_idle_pct = 26;
		recv_idle_pct = 56;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = 1'b0;
		adc_sample    = '0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_NOTIFY;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default baseline, validity edges and full scale.
		send_request(1'b0, 0);
		send_request(1'b0, 61);
		send_request(1'b0, 62);
		send_request(1'b0, 2000);
		send_request(1'b0, 4095);
		send_request(1'b0, 3000);
		// A zero target acts as one: an invalid sample gives a zero baseline.
		write_reg(REG_CAL, 0);
		send_request(1'b1, 0);
		send_request(1'b0, 1500);
		// Baseline from the highest and lowest valid resistance.
		send_request(1'b1, 62);
		send_request(1'b0, 4095);
		send_request(1'b0, 62);
		send_request(1'b1, 4095);
		send_request(1'b0, 62);
		send_request(1'b0, 4095);
		// Zero thresholds and a two-sample calibration run, then thresholds near the top of their range.
		write_reg(REG_NOTIFY, 0);
		write_reg(REG_ALERT, 0);
		write_reg(REG_RAPID, 0);
		write_reg(REG_CAL, 2);
		send_request(1'b1, 1000);
		send_request(1'b1, 1200);
		send_request(1'b0, 1100);
		send_request(1'b0, 2500);
		send_request(1'b0, 3500);
		write_reg(REG_NOTIFY, 1000);
		write_reg(REG_ALERT, 1000);
		write_reg(REG_RAPID, 1000);
		send_request(1'b0, 4000);
		send_request(1'b0, 100);
		send_request(1'b0, 4095);

		// Random, with a random calibration target and then short calibration runs.
		write_reg(REG_NOTIFY, $urandom_range(1023));
		write_reg(REG_ALERT, $urandom_range(200));
		write_reg(REG_RAPID, $urandom_range(60));
		write_reg(REG_CAL, $urandom_range(1023));
		random_phase(300, 20);
		write_reg(REG_CAL, $urandom_range(1, 8));
		random_phase(400, 15);

		// Sender idles more than the receiver; longest calibration run.
		send_idle_pct = 56;
		recv_idle_pct = 26;
		write_reg(REG_NOTIFY, $urandom_range(100));
		write_reg(REG_ALERT, $urandom_range(1000));
		write_reg(REG_RAPID, $urandom_range(30));
		write_reg(REG_CAL, 255);
		random_phase(700, 45);

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_NOTIFY, $urandom_range(1000));
		write_reg(REG_ALERT, $urandom_range(1000));
		write_reg(REG_RAPID, $urandom_range(1023));
		write_reg(REG_CAL, $urandom_range(1, 4));
		random_phase(600, 15);

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
